### hdl/bos_pkg.sv
// package for the box overlap suppression block: sizes, types and states
`default_nettype none
package bos_pkg;
  localparam int MaxBoxes  = 64;
  localparam int CoordBits = 12;
  localparam int SizeBits  = CoordBits + 1;
  localparam int IdxBits   = $clog2(MaxBoxes);
  localparam int CntBits   = IdxBits + 1;
  localparam int AreaBits  = 2 * SizeBits;
  localparam int EdgeBits  = CoordBits + 2;
  localparam int RatioBits = 10;
  localparam int BoxBits   = 2 * CoordBits + 2 * SizeBits;
  localparam int AddrBits  = 1;
  localparam logic [AddrBits-1:0] RegSuppressRatio = 1'b0;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [SizeBits-1:0]  w;
    logic [SizeBits-1:0]  h;
  } box_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SCAN_RD, ST_SCAN, ST_PICK_RD, ST_EMIT, ST_SUP_RD, ST_SUP_OV,
    ST_SUP_MUL, ST_SUP_CMP, ST_DONE
  } state_t;
endpackage
`default_nettype wire

### hdl/bos_ram.sv
// generic single port ram with registered read
`default_nettype none
module bos_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### hdl/box_overlap_suppression.sv
// box overlap suppression top level: load, sequencer and shared multiplier
//
//  channel  | handshake            | payload
//  input    | in_valid / in_stall  | box_x box_y box_width box_height set_empty set_last
//  output   | out_valid / out_stall| kept_x kept_y kept_width kept_height capacity_overflow final_kept
//  config   | apb psel/penable     | suppress_ratio at address 0
//
// boxes load one per cycle; after the closing item in_stall stays high while
// the sequencer runs rounds: a scan (scan_rd, scan per stored box) for the smallest
// area, a pick read and an emit step, then a suppression pass (sup_rd, sup_ov,
// sup_mul, sup_cmp per stored box) through one shared multiplier.
// a held output stalls the sequencer at the emit and done steps; each kept box
// leaves at the next emit or done step. rst clears the state, counts, flags,
// alive bits and ratio; the box data registers are not reset.
`default_nettype none
module box_overlap_suppression (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bos_pkg::CoordBits-1:0]  box_x,
  input  wire logic [bos_pkg::CoordBits-1:0]  box_y,
  input  wire logic [bos_pkg::SizeBits-1:0]   box_width,
  input  wire logic [bos_pkg::SizeBits-1:0]   box_height,
  input  wire logic                           set_empty,
  input  wire logic                           set_last,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [bos_pkg::CoordBits-1:0]  kept_x,
  output logic      [bos_pkg::CoordBits-1:0]  kept_y,
  output logic      [bos_pkg::SizeBits-1:0]   kept_width,
  output logic      [bos_pkg::SizeBits-1:0]   kept_height,
  output logic                                capacity_overflow,
  output logic                                final_kept,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bos_pkg::AddrBits+1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);
  localparam int N = bos_pkg::MaxBoxes;
  localparam int IB = bos_pkg::IdxBits;
  localparam int CB = bos_pkg::CntBits;
  localparam int AB = bos_pkg::AreaBits;
  localparam int EB = bos_pkg::EdgeBits;
  localparam int MB = 2 * AB;

  bos_pkg::state_t state, state_next;
  logic [bos_pkg::RatioBits-1:0] suppress_ratio;
  logic [CB-1:0] loaded_count;
  logic          overflow_seen;
  logic [N-1:0]  alive;
  logic [IB-1:0] idx;
  logic [IB-1:0] pick;
  logic          found;
  logic [AB-1:0] best;
  logic [CB-1:0] emitted;
  bos_pkg::box_t pbox, rbox, wbox;
  logic [IB-1:0] raddr;
  logic          we;
  logic [AB-1:0] parea;
  logic [EB-1:0] ow, oh;
  logic [AB-1:0] ov, amin;
  logic [AB-1:0] mul_a, mul_b;
  logic [MB-1:0] mul_p;
  logic          accept, closing, last_idx;
  logic          out_free, out_load;

  assign pready = 1'b1;
  assign prdata = {{(32 - bos_pkg::RatioBits){1'b0}}, suppress_ratio};

  always_ff @(posedge clk) begin
    if (rst) begin
      suppress_ratio <= bos_pkg::RatioBits'(128);
    end else if (psel && penable && pwrite &&
                 paddr[bos_pkg::AddrBits+1:2] == bos_pkg::RegSuppressRatio) begin
      suppress_ratio <= pwdata[bos_pkg::RatioBits-1:0];
    end
  end

  assign accept   = in_valid && !in_stall;
  assign closing  = accept && (set_empty || set_last);
  assign in_stall = (state != bos_pkg::ST_LOAD);
  assign last_idx = ({1'b0, idx} == loaded_count - CB'(1));
  assign out_free = !out_valid || !out_stall;
  assign out_load = ((state == bos_pkg::ST_EMIT) || (state == bos_pkg::ST_DONE)) &&
                    out_free && (emitted != '0);

  assign wbox = '{x: box_x, y: box_y, w: box_width, h: box_height};
  assign we   = accept && !set_empty && (loaded_count < CB'(N));
  always_comb begin
    unique case (state) inside
      bos_pkg::ST_LOAD:                     raddr = loaded_count[IB-1:0];
      bos_pkg::ST_PICK_RD, bos_pkg::ST_EMIT: raddr = pick;
      default:                              raddr = idx;
    endcase
  end

  bos_ram #(.Width(bos_pkg::BoxBits), .Depth(N)) u_store (
    .clk(clk), .we(we), .addr(raddr), .wdata(wbox), .rdata(rbox)
  );

  // shared multiplier: box area, overlap, or threshold times min area
  always_comb begin
    mul_a = AB'(rbox.w);
    mul_b = AB'(rbox.h);
    if (state == bos_pkg::ST_SUP_OV) begin
      mul_a = AB'(ow);
      mul_b = AB'(oh);
    end else if (state == bos_pkg::ST_SUP_CMP) begin
      mul_a = AB'(suppress_ratio);
      mul_b = amin;
    end
  end
  assign mul_p = MB'(mul_a) * MB'(mul_b);

  // inclusive edge overlap spans
  function automatic logic [EB-1:0] span(input logic [bos_pkg::CoordBits-1:0] a0,
                                         input logic [bos_pkg::SizeBits-1:0] al,
                                         input logic [bos_pkg::CoordBits-1:0] b0,
                                         input logic [bos_pkg::SizeBits-1:0] bl);
    logic [EB-1:0] lo, ea, eb, hi;
    lo = (a0 > b0) ? EB'(a0) : EB'(b0);
    ea = EB'(a0) + EB'(al);
    eb = EB'(b0) + EB'(bl);
    hi = (ea < eb) ? ea : eb;
    return (hi + EB'(1) > lo) ? (hi + EB'(1) - lo) : '0;
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      bos_pkg::ST_LOAD:
        if (closing) state_next = bos_pkg::ST_SCAN_RD;
      bos_pkg::ST_SCAN_RD: state_next = bos_pkg::ST_SCAN;
      bos_pkg::ST_SCAN:
        if (last_idx || loaded_count == '0)
          state_next = bos_pkg::ST_PICK_RD;
        else state_next = bos_pkg::ST_SCAN_RD;
      bos_pkg::ST_PICK_RD:
        state_next = found ? bos_pkg::ST_EMIT : bos_pkg::ST_DONE;
      bos_pkg::ST_EMIT:
        if (out_free) state_next = bos_pkg::ST_SUP_RD;
      bos_pkg::ST_SUP_RD: state_next = bos_pkg::ST_SUP_OV;
      bos_pkg::ST_SUP_OV: state_next = bos_pkg::ST_SUP_MUL;
      bos_pkg::ST_SUP_MUL: state_next = bos_pkg::ST_SUP_CMP;
      bos_pkg::ST_SUP_CMP:
        state_next = last_idx ? bos_pkg::ST_SCAN_RD : bos_pkg::ST_SUP_RD;
      bos_pkg::ST_DONE:
        if (out_free) state_next = bos_pkg::ST_LOAD;
      default: state_next = bos_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bos_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count  <= '0;
      overflow_seen <= 1'b0;
      alive         <= '0;
      idx           <= '0;
      found         <= 1'b0;
      out_valid     <= 1'b0;
      emitted       <= '0;
    end else begin
      unique case (state)
        bos_pkg::ST_LOAD: begin
          if (we) begin
            alive[loaded_count[IB-1:0]] <= 1'b1;
            loaded_count <= loaded_count + CB'(1);
          end else if (accept && !set_empty) begin
            overflow_seen <= 1'b1;
          end
          idx   <= '0;
          found <= 1'b0;
          emitted <= '0;
        end
        bos_pkg::ST_SCAN: begin
          if (loaded_count != '0 && alive[idx] && (!found || mul_p[AB-1:0] < best)) begin
            found <= 1'b1;
            best  <= mul_p[AB-1:0];
            pick  <= idx;
          end
          idx <= last_idx ? '0 : idx + IB'(1);
        end
        bos_pkg::ST_EMIT: begin
          if (out_free) begin
            alive[pick] <= 1'b0;
            parea <= best;
            emitted <= emitted + CB'(1);
            idx <= '0;
          end
        end
        bos_pkg::ST_SUP_OV: begin
          ov <= mul_p[AB-1:0];
        end
        bos_pkg::ST_SUP_MUL: begin
          amin <= (mul_p[AB-1:0] < parea) ? mul_p[AB-1:0] : parea;
        end
        bos_pkg::ST_SUP_CMP: begin
          if (alive[idx] && ({{(MB - AB - 8){1'b0}}, ov, 8'b0} > mul_p))
            alive[idx] <= 1'b0;
          idx <= last_idx ? '0 : idx + IB'(1);
          found <= 1'b0;
        end
        bos_pkg::ST_DONE: begin
          if (out_free) begin
            loaded_count  <= '0;
            overflow_seen <= 1'b0;
            alive         <= '0;
          end
        end
        default: ;
      endcase
      // the previous pick leaves when the next one is emitted or the set is done
      if (out_load) begin
        out_valid <= 1'b1;
        final_kept <= (state == bos_pkg::ST_DONE);
        kept_x <= pbox.x; kept_y <= pbox.y;
        kept_width <= pbox.w; kept_height <= pbox.h;
        capacity_overflow <= overflow_seen;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // picked box held for the suppression pass
  always_ff @(posedge clk) begin
    if (state == bos_pkg::ST_EMIT && out_free) begin
      pbox <= rbox;
    end
  end

  always_comb begin
    ow = span(pbox.x, pbox.w, rbox.x, rbox.w);
    oh = span(pbox.y, pbox.h, rbox.y, rbox.h);
  end
endmodule
`default_nettype wire

### tb/box_overlap_suppression_tb.sv
// self-checking testbench for the box overlap suppression block
`default_nettype none
module box_overlap_suppression_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CoordBits = bos_pkg::CoordBits;
  localparam int SizeBits  = bos_pkg::SizeBits;
  localparam int AddrBits  = bos_pkg::AddrBits;
  localparam int RatioBits = bos_pkg::RatioBits;
  localparam int MaxBoxes  = bos_pkg::MaxBoxes;
  localparam logic [AddrBits-1:0] RegSuppressRatio = bos_pkg::RegSuppressRatio;

  typedef struct {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [SizeBits-1:0]  w;
    logic [SizeBits-1:0]  h;
    logic                 empty;
    logic                 last;
  } box_item_t;

  typedef struct {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [SizeBits-1:0]  w;
    logic [SizeBits-1:0]  h;
    logic                 ovf;
    logic                 fin;
  } kept_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CoordBits-1:0] box_x = '0;
  logic [CoordBits-1:0] box_y = '0;
  logic [SizeBits-1:0]  box_width = 13'd1;
  logic [SizeBits-1:0]  box_height = 13'd1;
  logic set_empty = 1'b0;
  logic set_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CoordBits-1:0] kept_x;
  logic [CoordBits-1:0] kept_y;
  logic [SizeBits-1:0]  kept_width;
  logic [SizeBits-1:0]  kept_height;
  logic capacity_overflow;
  logic final_kept;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrBits+1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  box_overlap_suppression dut (.*);

  always #4 clk = ~clk;

  box_item_t  pending_boxes[$];
  kept_item_t kept_expected[$];
  box_item_t  set_boxes[$];
  logic [RatioBits-1:0] ratio_model = 10'd128;
  int  mismatches = 0;
  bit  quiet = 1'b0;
  bit  hold_off = 1'b0;
  bit  set_overflow = 1'b0;
  // in_stall as seen at the last rising edge
  logic in_stall_q = 1'b0;

  function automatic logic [63:0] span_ov(logic [63:0] a0, logic [63:0] al,
                                          logic [63:0] b0, logic [63:0] bl);
    logic [63:0] lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
    return (hi + 64'd1 > lo) ? hi + 64'd1 - lo : 64'd0;
  endfunction

  task automatic add_item(box_item_t b);
    pending_boxes.insert(pending_boxes.size(), b);
  endtask

  // greedy smallest-area pick with overlap suppression over the closed set
  task automatic predict_kept();
    bit alive[MaxBoxes];
    int pick, n;
    logic [63:0] best, ar, ab, ov, amin;
    box_item_t p;
    kept_item_t k;
    n = 0;
    foreach (set_boxes[i]) alive[i] = 1'b1;
    forever begin
      pick = -1;
      best = '0;
      foreach (set_boxes[i]) begin
        ar = 64'(set_boxes[i].w) * 64'(set_boxes[i].h);
        if (alive[i] && (pick < 0 || ar < best)) begin
          pick = i;
          best = ar;
        end
      end
      if (pick < 0) break;
      alive[pick] = 1'b0;
      p = set_boxes[pick];
      k.x = p.x; k.y = p.y; k.w = p.w; k.h = p.h;
      k.ovf = (set_overflow != 0);
      k.fin = 1'b0;
      kept_expected.insert(kept_expected.size(), k);
      n++;
      foreach (set_boxes[i]) begin
        if (alive[i]) begin
          ov = span_ov(64'(p.x), 64'(p.w), 64'(set_boxes[i].x), 64'(set_boxes[i].w)) *
               span_ov(64'(p.y), 64'(p.h), 64'(set_boxes[i].y), 64'(set_boxes[i].h));
          ar = 64'(p.w) * 64'(p.h);
          ab = 64'(set_boxes[i].w) * 64'(set_boxes[i].h);
          amin = (ar < ab) ? ar : ab;
          if (ov * 64'd256 > 64'(ratio_model) * amin) alive[i] = 1'b0;
        end
      end
    end
    if (n > 0) kept_expected[$].fin = 1'b1;
    set_boxes.delete();
  endtask

  task automatic model_item(box_item_t b);
    if (!b.empty) begin
      if (set_boxes.size() < MaxBoxes) set_boxes.insert(set_boxes.size(), b);
      else set_overflow = 1'b1;
    end
    if (b.empty || b.last) begin
      predict_kept();
      set_overflow = 1'b0;
    end
  endtask

  // driver: next item at the falling edge once the current one was taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall_q) begin
        if (pending_boxes.size() > 0 && !hold_off && (quiet || $urandom_range(99) >= 16)) begin
          box_x <= pending_boxes[0].x;
          box_y <= pending_boxes[0].y;
          box_width <= pending_boxes[0].w;
          box_height <= pending_boxes[0].h;
          set_empty <= pending_boxes[0].empty;
          set_last <= pending_boxes[0].last;
          model_item(pending_boxes.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) in_stall_q <= in_stall;

  // monitor
  always @(posedge clk) begin
    kept_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (kept_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected kept item x=%0d y=%0d", kept_x, kept_y);
      end else begin
        e = kept_expected.pop_front();
        if (e.x !== kept_x || e.y !== kept_y || e.w !== kept_width ||
            e.h !== kept_height || e.ovf !== capacity_overflow || e.fin !== final_kept) begin
          mismatches++;
          if (mismatches <= 10)
            $display("kept mismatch exp %0d %0d %0d %0d %0b %0b got %0d %0d %0d %0d %0b %0b",
                     e.x, e.y, e.w, e.h, e.ovf, e.fin, kept_x, kept_y, kept_width,
                     kept_height, capacity_overflow, final_kept);
        end
      end
    end
  end

  function automatic box_item_t mk(int x, int y, int w, int h, bit em, bit la);
    box_item_t b;
    b.x = CoordBits'(x); b.y = CoordBits'(y);
    b.w = SizeBits'(w); b.h = SizeBits'(h);
    b.empty = em; b.last = la;
    return b;
  endfunction

  function automatic box_item_t rand_box(bit la);
    box_item_t b;
    int r;
    r = $urandom_range(3);
    b.x = CoordBits'((r == 0) ? $urandom : $urandom_range(200));
    b.y = CoordBits'((r == 0) ? $urandom : $urandom_range(200));
    b.w = SizeBits'((r == 0) ? $urandom : 1 + $urandom_range(120));
    b.h = SizeBits'((r == 0) ? $urandom : 1 + $urandom_range(120));
    b.empty = 1'b0;
    b.last = la;
    return b;
  endfunction

  task automatic wait_idle();
    while (pending_boxes.size() > 0 || in_valid || kept_expected.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_ratio(int v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {RegSuppressRatio, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    ratio_model = RatioBits'(v);
  endtask

  task automatic queue_sets(int items);
    int n, k;
    k = 0;
    while (k < items) begin
      n = ($urandom_range(19) == 0) ? 60 + $urandom_range(8) : 1 + $urandom_range(8);
      if ($urandom_range(14) == 0) begin
        add_item(mk($urandom, $urandom, $urandom, $urandom, 1'b1, 1'($urandom_range(1))));
        k++;
      end else begin
        for (int i = 0; i < n; i++) add_item(rand_box(i == n - 1));
        k += n;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: extremes, ties, nesting, empty closes
    add_item(mk(0, 0, 1, 1, 1'b0, 1'b0));
    add_item(mk(4095, 4095, 4096, 4096, 1'b0, 1'b0));
    add_item(mk(0, 0, 4096, 4096, 1'b0, 1'b0));
    add_item(mk(0, 0, 1, 1, 1'b0, 1'b0));
    add_item(mk(4095, 0, 1, 4096, 1'b0, 1'b1));
    add_item(mk(10, 10, 5, 5, 1'b1, 1'b1));
    add_item(mk(0, 0, 0, 0, 1'b1, 1'b0));
    add_item(mk(10, 10, 20, 20, 1'b0, 1'b0));
    add_item(mk(15, 15, 20, 20, 1'b0, 1'b0));
    add_item(mk(100, 100, 4, 4, 1'b0, 1'b0));
    add_item(mk(12, 12, 4, 4, 1'b1, 1'b0));
    add_item(mk(11, 11, 10, 10, 1'b0, 1'b1));
    for (int i = 0; i < 66; i++) add_item(mk(i * 3, i, 2, 2, 1'b0, i == 65));
    wait_idle();
    write_ratio(0);
    queue_sets(55);
    wait_idle();
    write_ratio(1023);
    queue_sets(55);
    // sender holds until everything has drained, then resumes
    wait (pending_boxes.size() < 20);
    hold_off = 1'b1;
    while (in_valid || kept_expected.size() > 0) @(posedge clk);
    hold_off = 1'b0;
    wait_idle();
    write_ratio($urandom_range(1023));
    quiet = 1'b1;
    queue_sets(55);
    wait_idle();
    quiet = 1'b0;
    write_ratio(256);
    queue_sets(55);
    wait_idle();
    write_ratio(128);
    queue_sets(55);
    wait_idle();
    if (mismatches == 0 && kept_expected.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
